// ===== design/greedy_box_nms_core_assert.svh =====
// assertion helpers for the rtl files, included by gbn_ctrl
`ifndef GREEDY_BOX_NMS_CORE_ASSERT_SVH
`define GREEDY_BOX_NMS_CORE_ASSERT_SVH

// plain property, sampled on clk_i, off during reset
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// types, constants and helpers of the greedy box suppression core
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ExtW   = 17;
  localparam int unsigned AreaW  = 34;
  localparam int unsigned UniW   = 35;
  localparam int unsigned ProdW  = 51;
  localparam int unsigned LimW   = 7;
  localparam int unsigned ThrW   = 16;

  localparam logic [ExtW-1:0]   PIXEL_ONE       = 17'd16;
  localparam logic [ThrW-1:0]   RST_OVERLAP     = 16'd45875;
  localparam logic [LimW-1:0]   RST_MAX_CONSID  = 7'd64;
  localparam logic [LimW-1:0]   RST_MAX_KEPT    = 7'd64;

  typedef enum logic [1:0] {
    CFG_OVERLAP   = 2'd0,
    CFG_MAX_CONSID = 2'd1,
    CFG_MAX_KEPT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FIND,
    ST_SUPP,
    ST_EMIT
  } gbn_state_e;

  typedef struct packed {
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic [15:0] box_score;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [5:0]  pick_index;
    logic [15:0] pick_x1;
    logic [15:0] pick_y1;
    logic [15:0] pick_x2;
    logic [15:0] pick_y2;
    logic [15:0] pick_score;
    logic        last_pick;
  } pick_out_t;

  // one stored box
  typedef struct packed {
    logic [15:0] score;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
  } entry_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic find_start;
    logic supp_start;
  } gbn_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic live_any;
    logic load_full;
    logic cnt_zero;
  } gbn_stat_t;

  // extent with the plus-one pixel rule, clamped at zero
  function automatic logic [ExtW-1:0] extent(input logic [CoordW-1:0] lo,
                                             input logic [CoordW-1:0] hi);
    logic [ExtW-1:0] top;
    top = {1'b0, hi} + PIXEL_ONE;
    return (top > {1'b0, lo}) ? (top - {1'b0, lo}) : '0;
  endfunction

endpackage

// ===== design/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gbn_dp.sv =====
// ----------------------------------------------------------------------------
// gbn_dp
// box store, scan counter, best-score search and overlap test pipeline
// ----------------------------------------------------------------------------
module gbn_dp import gbn_pkg::*; #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gbn_cmd_t                         cmd_i,
  output gbn_stat_t                        stat_o,
  input  box_in_t                          box_i,
  input  logic [$clog2(MAX_BOXES+1)-1:0]   load_lim_i,
  input  logic [ThrW-1:0]                  thr_i,
  output logic [5:0]                       best_idx_o,
  output entry_t                           best_o
);

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned IdxW = $clog2(MAX_BOXES);

  logic [CntW-1:0]      cnt_q;
  logic [MAX_BOXES-1:0] live_q;
  logic                 full;
  logic                 wr_en;
  entry_t               wr_entry;
  entry_t               rd_entry;

  logic            scan_act_q, scan_supp_q;
  logic [IdxW-1:0] scan_idx_q;
  logic            scan_end;

  logic            rd_v_q, rd_supp_q;
  logic [IdxW-1:0] rd_idx_q;

  logic            found_q;
  entry_t          best_q;
  logic [IdxW-1:0] best_idx_q;

  logic            e_v_q, m_v_q, u_v_q, p_v_q;
  logic [IdxW-1:0] e_idx_q, m_idx_q, u_idx_q, p_idx_q;
  logic [ExtW-1:0] ex_q, ey_q, bx_q, by_q, ax_q, ay_q;
  logic [AreaW-1:0] inter_m_q, ab_q, aa_q, inter_u_q, inter_p_q;
  logic [UniW-1:0]  uni_q;
  logic [ProdW-1:0] prod_q;
  logic             kill;

  assign full     = (cnt_q >= load_lim_i);
  assign wr_en    = cmd_i.load && !full;
  assign wr_entry = '{score: box_i.box_score, x1: box_i.box_x1, y1: box_i.box_y1,
                      x2: box_i.box_x2, y2: box_i.box_y2};

  gbn_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (scan_act_q),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_entry)
  );

  // load count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // scan address counter
  assign scan_end = ({1'b0, scan_idx_q} + (IdxW+1)'(1)) >= (IdxW+1)'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q  <= 1'b0;
      scan_supp_q <= 1'b0;
      scan_idx_q  <= '0;
      rd_v_q      <= 1'b0;
      rd_supp_q   <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      rd_v_q    <= scan_act_q;
      rd_supp_q <= scan_supp_q;
      rd_idx_q  <= scan_idx_q;
      if (cmd_i.find_start || cmd_i.supp_start) begin
        scan_act_q  <= 1'b1;
        scan_supp_q <= cmd_i.supp_start;
        scan_idx_q  <= '0;
      end else if (scan_act_q) begin
        if (scan_end) begin
          scan_act_q <= 1'b0;
        end else begin
          scan_idx_q <= scan_idx_q + IdxW'(1);
        end
      end
    end
  end

  // best live score, higher index wins ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.find_start) begin
      found_q <= 1'b0;
    end else if (rd_v_q && !rd_supp_q && live_q[rd_idx_q] &&
                 (!found_q || rd_entry.score >= best_q.score)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q && !rd_supp_q && live_q[rd_idx_q] &&
        (!found_q || rd_entry.score >= best_q.score)) begin
      best_q     <= rd_entry;
      best_idx_q <= rd_idx_q;
    end
  end

  // overlap pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      m_v_q <= 1'b0;
      u_v_q <= 1'b0;
      p_v_q <= 1'b0;
    end else begin
      e_v_q <= rd_v_q && rd_supp_q;
      m_v_q <= e_v_q;
      u_v_q <= m_v_q;
      p_v_q <= u_v_q;
    end
  end

  // extents, products, union, threshold product
  always_ff @(posedge clk_i) begin
    e_idx_q <= rd_idx_q;
    ex_q <= extent((best_q.x1 > rd_entry.x1) ? best_q.x1 : rd_entry.x1,
                   (best_q.x2 < rd_entry.x2) ? best_q.x2 : rd_entry.x2);
    ey_q <= extent((best_q.y1 > rd_entry.y1) ? best_q.y1 : rd_entry.y1,
                   (best_q.y2 < rd_entry.y2) ? best_q.y2 : rd_entry.y2);
    bx_q <= extent(rd_entry.x1, rd_entry.x2);
    by_q <= extent(rd_entry.y1, rd_entry.y2);
    ax_q <= extent(best_q.x1, best_q.x2);
    ay_q <= extent(best_q.y1, best_q.y2);

    m_idx_q   <= e_idx_q;
    inter_m_q <= AreaW'(ex_q) * AreaW'(ey_q);
    ab_q      <= AreaW'(bx_q) * AreaW'(by_q);
    aa_q      <= AreaW'(ax_q) * AreaW'(ay_q);

    u_idx_q   <= m_idx_q;
    inter_u_q <= inter_m_q;
    uni_q     <= UniW'(aa_q) + UniW'(ab_q) - UniW'(inter_m_q);

    p_idx_q   <= u_idx_q;
    inter_p_q <= inter_u_q;
    prod_q    <= ProdW'(thr_i) * ProdW'(uni_q);
  end

  assign kill = p_v_q && (({1'b0, inter_p_q, 16'h0000} > prod_q) || (p_idx_q == best_idx_q));

  // live mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.clear) begin
      live_q <= '0;
    end else begin
      if (wr_en) begin
        live_q[cnt_q[IdxW-1:0]] <= 1'b1;
      end
      if (kill) begin
        live_q[p_idx_q] <= 1'b0;
      end
    end
  end

  assign stat_o.scan_done = !scan_act_q && !rd_v_q && !e_v_q && !m_v_q && !u_v_q && !p_v_q;
  assign stat_o.live_any  = |live_q;
  assign stat_o.load_full = full;
  assign stat_o.cnt_zero  = (cnt_q == '0);

  assign best_idx_o = 6'(best_idx_q);
  assign best_o     = best_q;

endmodule

// ===== design/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// sequencer: load, find best, suppress, emit
// ----------------------------------------------------------------------------
module gbn_ctrl import gbn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            last_box_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            last_pick_o,
  input  logic [LimW-1:0] keep_lim_i,
  input  gbn_stat_t       stat_i,
  output gbn_cmd_t        cmd_o
);

  gbn_state_e      state_q, state_d;
  logic [LimW-1:0] kept_q, kept_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      kept_q  <= '0;
    end else begin
      state_q <= state_d;
      kept_q  <= kept_d;
    end
  end

  assign last_pick_o = !stat_i.live_any || ((kept_q + LimW'(1)) == keep_lim_i);

  // next state and commands
  always_comb begin
    state_d     = state_q;
    kept_d      = kept_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_box_i) begin
            if ((!stat_i.cnt_zero || !stat_i.load_full) && (keep_lim_i != '0)) begin
              cmd_o.find_start = 1'b1;
              kept_d           = '0;
              state_d          = ST_FIND;
            end else begin
              cmd_o.clear = 1'b1;
            end
          end
        end
      end
      ST_FIND: begin
        if (stat_i.scan_done) begin
          cmd_o.supp_start = 1'b1;
          state_d          = ST_SUPP;
        end
      end
      ST_SUPP: begin
        if (stat_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          kept_d = kept_q + LimW'(1);
          if (last_pick_o) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.find_start = 1'b1;
            state_d          = ST_FIND;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

`include "greedy_box_nms_core_assert.svh"

  `GBN_ASSERT(a_no_in_and_out, !(in_ready_o && out_valid_o), "input and output open together")
  `GBN_ASSERT_IMP(a_kept_in_limit, out_valid_o, kept_q < keep_lim_i, "pick beyond keep limit")
  `GBN_ASSERT_NXT(a_last_ends_set, out_valid_o && out_ready_i && last_pick_o, in_ready_o, "set did not close after final pick")
  `GBN_ASSERT_IMP(a_emit_has_live_pick, out_valid_o, stat_i.scan_done, "emit while scan running")

endmodule

// ===== design/greedy_box_nms_core.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// greedy iou non-maximum suppression over a loaded set of scored boxes
// ----------------------------------------------------------------------------
// Boxes arrive on the in channel (valid/ready), one transfer per cycle while
// loading; up to min(max_considered, MAX_BOXES) are stored, extras dropped.
// The transfer with last_box set closes the set and starts suppression; the
// input stays closed until the final pick of the set has been transferred.
// Each pick costs one score scan over the loaded boxes and one overlap scan
// through the iou pipeline, both driven by a single read port of the box
// ram, then one transfer on the out channel.
// The out channel holds its result while out_ready_i is low; the sequencer
// waits in that state and no state is lost. last_pick marks the final result.
// An empty set, or max_kept of zero, gives no result and the input stays
// open. Reset (rst_ni low, asynchronous) empties the set and restores the
// register defaults; the box ram itself is not cleared. Registers are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write
// them only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module greedy_box_nms_core import gbn_pkg::*; #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  box_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pick_out_t   out_o
);

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  logic [ThrW-1:0] overlap_q;
  logic [LimW-1:0] max_consid_q;
  logic [LimW-1:0] max_kept_q;
  logic [CntW-1:0] load_lim;
  logic [LimW-1:0] keep_lim;
  gbn_cmd_t        cmd;
  gbn_stat_t       stat;
  logic [5:0]      best_idx;
  entry_t          best;
  logic            last_pick;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_q    <= RST_OVERLAP;
      max_consid_q <= RST_MAX_CONSID;
      max_kept_q   <= RST_MAX_KEPT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OVERLAP:    overlap_q    <= cfg_wdata_i;
        CFG_MAX_CONSID: max_consid_q <= cfg_wdata_i[LimW-1:0];
        CFG_MAX_KEPT:   max_kept_q   <= cfg_wdata_i[LimW-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp limits to the store depth
  assign load_lim = (max_consid_q > LimW'(MAX_BOXES)) ? CntW'(MAX_BOXES) : CntW'(max_consid_q);
  assign keep_lim = (max_kept_q > LimW'(MAX_BOXES)) ? LimW'(MAX_BOXES) : max_kept_q;

  gbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_box_i  (in_i.last_box),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_pick_o (last_pick),
    .keep_lim_i  (keep_lim),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gbn_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .box_i      (in_i),
    .load_lim_i (load_lim),
    .thr_i      (overlap_q),
    .best_idx_o (best_idx),
    .best_o     (best)
  );

  // result payload
  assign out_o = '{pick_index: best_idx, pick_x1: best.x1, pick_y1: best.y1,
                   pick_x2: best.x2, pick_y2: best.y2, pick_score: best.score,
                   last_pick: last_pick};

endmodule

// ===== test/greedy_box_nms_core_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms_core_tb
// self-checking bench for the greedy iou box suppression core
// ----------------------------------------------------------------------------
// Boxes are sent in sets over the valid/ready input with random gaps. Each
// accepted box updates a local model of the stored set; a box closing the set
// runs greedy suppression in the model and queues the expected picks, which
// a checker process compares field by field with every output transfer.
// Registers are changed between sets once the core has gone idle.
// ----------------------------------------------------------------------------
module greedy_box_nms_core_tb;
  import gbn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBOX      = 64;
  localparam longint      CYCLE_CAP = 2000000;
  localparam int unsigned SETTLE    = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_OVERLAP;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  box_in_t     in_box = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pick_out_t   out_pick;

  greedy_box_nms_core #(.MAX_BOXES(NBOX)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_box),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_pick)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // model copy of registers and stored set
  logic [15:0] thr_q     = RST_OVERLAP;
  logic [6:0]  consid_q  = RST_MAX_CONSID;
  logic [6:0]  kept_q    = RST_MAX_KEPT;
  box_in_t     set_box [NBOX];
  logic [33:0] set_area [NBOX];
  logic [NBOX-1:0] set_live = '0;
  int unsigned set_cnt = 0;

  pick_out_t   pick_q [$];
  int unsigned errors = 0;
  longint      cycles = 0;
  int unsigned hold_req = 0;
  bit          no_idle = 1'b0;

  // cycle count and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [16:0] span(input logic [15:0] lo, input logic [15:0] hi);
    logic [16:0] top;
    top = {1'b0, hi} + 17'd16;
    span = (top > {1'b0, lo}) ? top - {1'b0, lo} : 17'd0;
  endfunction

  function automatic bit suppressed(input int unsigned a, input int unsigned b);
    logic [15:0] lx, ly, hx, hy;
    longint unsigned inter, uni;
    lx = (set_box[a].box_x1 > set_box[b].box_x1) ? set_box[a].box_x1 : set_box[b].box_x1;
    ly = (set_box[a].box_y1 > set_box[b].box_y1) ? set_box[a].box_y1 : set_box[b].box_y1;
    hx = (set_box[a].box_x2 < set_box[b].box_x2) ? set_box[a].box_x2 : set_box[b].box_x2;
    hy = (set_box[a].box_y2 < set_box[b].box_y2) ? set_box[a].box_y2 : set_box[b].box_y2;
    inter = longint'(span(lx, hx)) * longint'(span(ly, hy));
    uni = longint'(set_area[a]) + longint'(set_area[b]) - inter;
    suppressed = (inter << 16) > (longint'(thr_q) * uni);
  endfunction

  // load one box into the model; on the closing box run suppression
  task automatic predict_picks(input box_in_t b);
    int unsigned load_lim, keep_lim, n, best, i;
    bit found;
    pick_out_t p;
    load_lim = (consid_q > 7'(NBOX)) ? NBOX : 32'(consid_q);
    keep_lim = (kept_q > 7'(NBOX)) ? NBOX : 32'(kept_q);
    if (set_cnt < load_lim) begin
      set_box[set_cnt] = b;
      set_area[set_cnt] = 34'(span(b.box_x1, b.box_x2)) * 34'(span(b.box_y1, b.box_y2));
      set_live[set_cnt] = 1'b1;
      set_cnt++;
    end
    if (!b.last_box) return;
    n = 0;
    while (set_live != '0 && n < keep_lim) begin
      found = 1'b0;
      best = 0;
      for (i = 0; i < set_cnt; i++) begin
        if (set_live[i] && (!found || set_box[i].box_score >= set_box[best].box_score)) begin
          best = i;
          found = 1'b1;
        end
      end
      p.pick_index = best[5:0];
      p.pick_x1 = set_box[best].box_x1;
      p.pick_y1 = set_box[best].box_y1;
      p.pick_x2 = set_box[best].box_x2;
      p.pick_y2 = set_box[best].box_y2;
      p.pick_score = set_box[best].box_score;
      p.last_pick = 1'b0;
      pick_q.insert(pick_q.size(), p);
      n++;
      for (i = 0; i < set_cnt; i++) begin
        if (set_live[i] && (i == best || suppressed(best, i))) set_live[i] = 1'b0;
      end
    end
    if (n > 0) pick_q[pick_q.size()-1].last_pick = 1'b1;
    set_live = '0;
    set_cnt = 0;
  endtask

  // send one box, keeping valid high across back-to-back transfers
  task automatic send_box(input box_in_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_box <= b;
    do @(posedge clk_i); while (!in_ready);
    predict_picks(b);
  endtask

  // wait for every pick, then for the core to settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OVERLAP:    thr_q = val;
      CFG_MAX_CONSID: consid_q = val[6:0];
      CFG_MAX_KEPT:   kept_q = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic box_in_t make_box(input logic [15:0] x1, input logic [15:0] y1,
                                       input logic [15:0] x2, input logic [15:0] y2,
                                       input logic [15:0] sc, input bit last);
    make_box = '{box_x1: x1, box_y1: y1, box_x2: x2, box_y2: y2,
                 box_score: sc, last_box: last};
  endfunction

  // box near a cluster centre, or a fully random one now and then
  function automatic box_in_t rand_box(input logic [15:0] cx, input logic [15:0] cy,
                                       input bit last);
    logic [15:0] x1, y1, sc;
    if ($urandom_range(0, 9) == 0)
      return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), last);
    x1 = cx + 16'($urandom_range(0, 96));
    y1 = cy + 16'($urandom_range(0, 96));
    sc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    return make_box(x1, y1, x1 + 16'($urandom_range(0, 400)),
                    y1 + 16'($urandom_range(0, 400)), sc, last);
  endfunction

  task automatic send_set(input int unsigned size);
    logic [15:0] cx, cy;
    cx = 16'($urandom);
    cy = 16'($urandom);
    for (int unsigned k = 0; k < size; k++) send_box(rand_box(cx, cy, k == size - 1));
  endtask

  // compare each output transfer with the oldest expected pick
  initial begin
    pick_out_t want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = hold_req > 0 ? hold_req : (no_idle ? 0 : $urandom_range(0, 11));
      hold_req = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (pick_q.size() == 0) begin
        $error("unexpected pick transfer, index %0d", out_pick.pick_index);
        errors++;
      end else begin
        want = pick_q.pop_front();
        if (out_pick.pick_index !== want.pick_index) begin
          $error("pick_index: expected %0d, got %0d", want.pick_index, out_pick.pick_index);
          errors++;
        end
        if (out_pick.pick_x1 !== want.pick_x1) begin
          $error("pick_x1: expected %0h, got %0h", want.pick_x1, out_pick.pick_x1);
          errors++;
        end
        if (out_pick.pick_y1 !== want.pick_y1) begin
          $error("pick_y1: expected %0h, got %0h", want.pick_y1, out_pick.pick_y1);
          errors++;
        end
        if (out_pick.pick_x2 !== want.pick_x2) begin
          $error("pick_x2: expected %0h, got %0h", want.pick_x2, out_pick.pick_x2);
          errors++;
        end
        if (out_pick.pick_y2 !== want.pick_y2) begin
          $error("pick_y2: expected %0h, got %0h", want.pick_y2, out_pick.pick_y2);
          errors++;
        end
        if (out_pick.pick_score !== want.pick_score) begin
          $error("pick_score: expected %0h, got %0h", want.pick_score, out_pick.pick_score);
          errors++;
        end
        if (out_pick.last_pick !== want.last_pick) begin
          $error("last_pick: expected %0b, got %0b", want.last_pick, out_pick.last_pick);
          errors++;
        end
      end
    end
  end

  // corner boxes, ties, reversed corners, dropped boxes
  task automatic test_directed;
    send_box(make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_box(make_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    // reversed corners give zero area
    send_box(make_box(16'h0800, 16'h0800, 16'h0100, 16'h0100, 16'h8000, 1'b0));
    send_box(make_box(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h4000, 1'b0));
    send_box(make_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h4000, 1'b1));
    // equal scores on identical boxes: higher position wins, rest killed
    send_box(make_box(16'h0100, 16'h0100, 16'h0300, 16'h0300, 16'h1234, 1'b0));
    send_box(make_box(16'h0100, 16'h0100, 16'h0300, 16'h0300, 16'h1234, 1'b0));
    send_box(make_box(16'h5000, 16'h5000, 16'h5100, 16'h5100, 16'h1234, 1'b1));
    drain;
    // drop on overflow, closing box dropped but still starts suppression
    write_reg(CFG_MAX_CONSID, 16'd2);
    send_box(make_box(16'h0010, 16'h0010, 16'h0040, 16'h0040, 16'h0001, 1'b0));
    send_box(make_box(16'h1000, 16'h1000, 16'h1040, 16'h1040, 16'h0002, 1'b0));
    send_box(make_box(16'h2000, 16'h2000, 16'h2040, 16'h2040, 16'hffff, 1'b0));
    send_box(make_box(16'h3000, 16'h3000, 16'h3040, 16'h3040, 16'hfffe, 1'b1));
    drain;
    // nothing loaded: empty set
    write_reg(CFG_MAX_CONSID, 16'hff80);
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b1));
    drain;
    write_reg(CFG_MAX_CONSID, 16'd127);
    write_reg(CFG_MAX_KEPT, 16'd0);
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b0));
    send_box(make_box(16'h0200, 16'h0200, 16'h0300, 16'h0300, 16'h0200, 1'b1));
    drain;
    write_reg(CFG_MAX_KEPT, 16'd1);
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b0));
    send_box(make_box(16'h4000, 16'h4000, 16'h4100, 16'h4100, 16'h0200, 1'b1));
    drain;
    // threshold extremes on partly overlapping boxes
    write_reg(CFG_MAX_KEPT, 16'd64);
    write_reg(CFG_OVERLAP, 16'd0);
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0300, 1'b0));
    send_box(make_box(16'h00f0, 16'h00f0, 16'h0200, 16'h0200, 16'h0200, 1'b0));
    send_box(make_box(16'h0300, 16'h0300, 16'h0400, 16'h0400, 16'h0100, 1'b1));
    drain;
    write_reg(CFG_OVERLAP, 16'hffff);
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0300, 1'b0));
    send_box(make_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0200, 1'b1));
    drain;
  endtask

  // a full set of the largest size
  task automatic test_full_set;
    write_reg(CFG_MAX_CONSID, 16'd64);
    write_reg(CFG_OVERLAP, 16'd30000);
    send_set(NBOX);
    drain;
  endtask

  // long receiver hold-off while the sender keeps offering boxes
  task automatic test_backpressure;
    hold_req = 600;
    send_set(6);
    send_set(5);
    send_set(4);
    drain;
  endtask

  // random sets, register settings changed between phases
  task automatic test_random;
    int unsigned sent, size;
    sent = 0;
    for (int unsigned phase = 0; sent < 170; phase++) begin
      write_reg(CFG_OVERLAP, (phase % 4 == 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom));
      write_reg(CFG_MAX_CONSID, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 6))
                                                             : 16'($urandom_range(8, 127)));
      write_reg(CFG_MAX_KEPT, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                           : 16'($urandom_range(4, 127)));
      no_idle = (phase % 5 == 3);
      for (int unsigned s = 0; s < 6; s++) begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_set(size);
        sent += size;
      end
      drain;
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed;
    test_full_set;
    test_backpressure;
    test_random;
    if (pick_q.size() != 0) begin
      $error("%0d expected picks never arrived", pick_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
